// ===== rtl/u2cal_pkg.sv =====
// ----------------------------------------------------------------------------
// u2cal_pkg
// Shared types, constants, the microcode program and the month table for the
// unix seconds to calendar date converter.
// ----------------------------------------------------------------------------
package u2cal_pkg;

  localparam int UPC_W     = 4;
  localparam int SECS_W    = 32;
  localparam int DAYS_W    = 16;
  localparam int YEAR_W    = 12;
  localparam int RECIP_W   = 26;
  localparam int PROD_W    = SECS_W + RECIP_W;

  localparam logic [SECS_W-1:0] DAY_SECS  = 32'd86400;
  localparam logic [SECS_W-1:0] HOUR_SECS = 32'd3600;
  localparam logic [SECS_W-1:0] MIN_SECS  = 32'd60;

  // x / 86400 = ((x >> 7) * 50903317) >> 35, exact for every 32-bit x
  localparam int                 DAY_PRE    = 7;
  localparam logic [RECIP_W-1:0] DAY_RECIP  = 26'd50903317;
  localparam int                 DAY_POST   = 35;
  // exact for any remainder below one day
  localparam int                 HOUR_PRE   = 4;
  localparam logic [RECIP_W-1:0] HOUR_RECIP = 26'd9321;
  localparam int                 HOUR_POST  = 21;
  // exact for any remainder below one hour
  localparam int                 MIN_PRE    = 2;
  localparam logic [RECIP_W-1:0] MIN_RECIP  = 26'd1093;
  localparam int                 MIN_POST   = 14;

  localparam logic [YEAR_W-1:0] BASE_YEAR    = 12'd1970;
  localparam logic [1:0]        BASE_MOD4    = 2'd2;
  localparam logic [6:0]        BASE_MOD100  = 7'd70;
  localparam logic [8:0]        BASE_MOD400  = 9'd370;
  localparam logic [6:0]        LAST_MOD100  = 7'd99;
  localparam logic [8:0]        LAST_MOD400  = 9'd399;
  localparam logic [8:0]        YEAR_DAYS    = 9'd365;
  localparam logic [8:0]        LEAP_DAYS    = 9'd366;
  localparam logic [3:0]        LAST_MONTH   = 4'd12;

  // program step addresses
  localparam logic [UPC_W-1:0] ST_IDLE  = 4'd0;
  localparam logic [UPC_W-1:0] ST_DIVD  = 4'd1;
  localparam logic [UPC_W-1:0] ST_REMD  = 4'd2;
  localparam logic [UPC_W-1:0] ST_YEAR  = 4'd3;
  localparam logic [UPC_W-1:0] ST_MONTH = 4'd4;
  localparam logic [UPC_W-1:0] ST_DIVH  = 4'd5;
  localparam logic [UPC_W-1:0] ST_REMH  = 4'd6;
  localparam logic [UPC_W-1:0] ST_DIVM  = 4'd7;
  localparam logic [UPC_W-1:0] ST_REMM  = 4'd8;
  localparam logic [UPC_W-1:0] ST_EMIT  = 4'd9;

  typedef enum logic [2:0] {
    OP_IDLE,
    OP_DIV,
    OP_REM,
    OP_YEAR,
    OP_MONTH,
    OP_NOP,
    OP_EMIT
  } op_t;

  typedef enum logic [1:0] {
    DS_DAY,
    DS_HOUR,
    DS_MIN
  } dsel_t;

  typedef enum logic [2:0] {
    C_NONE,
    C_NOACC,
    C_YGE,
    C_MGE,
    C_OBUSY,
    C_ALWAYS
  } cond_t;

  typedef struct packed {
    op_t              op;
    dsel_t            dsel;
    cond_t            cond;
    logic [UPC_W-1:0] target;
  } uword_t;

  typedef struct packed {
    logic y_ge;
    logic m_ge;
    logic out_busy;
  } status_t;

  function automatic uword_t ucode(input logic [UPC_W-1:0] addr);
    uword_t w;
    w = '{op: OP_NOP, dsel: DS_DAY, cond: C_NONE, target: ST_IDLE};
    case (addr)
      ST_IDLE: begin
        w.op = OP_IDLE; w.cond = C_NOACC; w.target = ST_IDLE;
      end
      ST_DIVD: begin
        w.op = OP_DIV; w.dsel = DS_DAY;
      end
      ST_REMD: begin
        w.op = OP_REM; w.dsel = DS_DAY;
      end
      ST_YEAR: begin
        w.op = OP_YEAR; w.cond = C_YGE; w.target = ST_YEAR;
      end
      ST_MONTH: begin
        w.op = OP_MONTH; w.cond = C_MGE; w.target = ST_MONTH;
      end
      ST_DIVH: begin
        w.op = OP_DIV; w.dsel = DS_HOUR;
      end
      ST_REMH: begin
        w.op = OP_REM; w.dsel = DS_HOUR;
      end
      ST_DIVM: begin
        // repeats harmlessly while the previous result still waits
        w.op = OP_DIV; w.dsel = DS_MIN; w.cond = C_OBUSY; w.target = ST_DIVM;
      end
      ST_REMM: begin
        w.op = OP_REM; w.dsel = DS_MIN;
      end
      ST_EMIT: begin
        w.op = OP_EMIT; w.cond = C_ALWAYS; w.target = ST_IDLE;
      end
      default: begin
        w.op = OP_NOP; w.cond = C_ALWAYS; w.target = ST_IDLE;
      end
    endcase
    return w;
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] n;
    case (m)
      4'd1:    n = 5'd31;
      4'd2:    n = leap ? 5'd29 : 5'd28;
      4'd3:    n = 5'd31;
      4'd4:    n = 5'd30;
      4'd5:    n = 5'd31;
      4'd6:    n = 5'd30;
      4'd7:    n = 5'd31;
      4'd8:    n = 5'd31;
      4'd9:    n = 5'd30;
      4'd10:   n = 5'd31;
      4'd11:   n = 5'd30;
      default: n = 5'd31;
    endcase
    return n;
  endfunction

endpackage

// ===== rtl/u2cal_useq.sv =====
// ----------------------------------------------------------------------------
// u2cal_useq
// Microprogram sequencer: step counter, control store and jump condition.
// ----------------------------------------------------------------------------
module u2cal_useq (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  u2cal_pkg::status_t stat,
  output u2cal_pkg::uword_t  ctl,
  output logic               in_ready
);
  import u2cal_pkg::*;

  logic [UPC_W-1:0] upc;
  logic [UPC_W-1:0] upc_next;
  logic             take;

  assign ctl      = ucode(upc);
  assign in_ready = (ctl.op == OP_IDLE);

  always_comb begin
    case (ctl.cond)
      C_NONE:   take = 1'b0;
      C_NOACC:  take = !in_valid;
      C_YGE:    take = stat.y_ge;
      C_MGE:    take = stat.m_ge;
      C_OBUSY:  take = stat.out_busy;
      C_ALWAYS: take = 1'b1;
      default:  take = 1'b0;
    endcase
    // the last step jumps back to idle
    upc_next = take ? ctl.target : upc + UPC_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= ST_IDLE;
    end else begin
      upc <= upc_next;
    end
  end

endmodule

// ===== rtl/u2cal_dp.sv =====
// ----------------------------------------------------------------------------
// u2cal_dp
// Datapath: reciprocal divider, year and month step-off, output register.
// ----------------------------------------------------------------------------
module u2cal_dp (
  input  logic               clk,
  input  logic               rst,
  input  u2cal_pkg::uword_t  ctl,
  input  logic               in_valid,
  input  logic [31:0]        epoch_seconds,
  input  logic               out_ready,
  output u2cal_pkg::status_t stat,
  output logic               out_valid,
  output logic [11:0]        year,
  output logic [3:0]         month,
  output logic [4:0]         day,
  output logic [4:0]         hour,
  output logic [5:0]         minute,
  output logic [5:0]         second
);
  import u2cal_pkg::*;

  logic [SECS_W-1:0] rem;
  logic [DAYS_W-1:0] days;
  logic [YEAR_W-1:0] yr;
  logic [1:0]        mod4;
  logic [6:0]        mod100;
  logic [8:0]        mod400;
  logic [3:0]        mon;
  logic [4:0]        hr;
  logic [5:0]        mn;

  logic [SECS_W-1:0]  base;
  logic [SECS_W-1:0]  scaled;
  logic [RECIP_W-1:0] recip;
  logic [PROD_W-1:0]  prod;
  logic [DAYS_W-1:0]  quo;
  logic [SECS_W-1:0]  qsel;
  logic [SECS_W-1:0]  back;
  logic               leap;
  logic [8:0]         ylen;
  logic [4:0]         mlen;
  logic               emit_fire;

  always_comb begin
    case (ctl.dsel)
      DS_DAY: begin
        base = DAY_SECS; scaled = rem >> DAY_PRE; recip = DAY_RECIP;
      end
      DS_HOUR: begin
        base = HOUR_SECS; scaled = rem >> HOUR_PRE; recip = HOUR_RECIP;
      end
      DS_MIN: begin
        base = MIN_SECS; scaled = rem >> MIN_PRE; recip = MIN_RECIP;
      end
      default: begin
        base = DAY_SECS; scaled = rem >> DAY_PRE; recip = DAY_RECIP;
      end
    endcase
  end

  assign prod = PROD_W'(scaled) * PROD_W'(recip);

  always_comb begin
    case (ctl.dsel)
      DS_DAY: begin
        quo = prod[DAY_POST +: DAYS_W]; qsel = SECS_W'(days);
      end
      DS_HOUR: begin
        quo = prod[HOUR_POST +: DAYS_W]; qsel = SECS_W'(hr);
      end
      DS_MIN: begin
        quo = prod[MIN_POST +: DAYS_W]; qsel = SECS_W'(mn);
      end
      default: begin
        quo = prod[DAY_POST +: DAYS_W]; qsel = SECS_W'(days);
      end
    endcase
  end

  assign back = qsel * base;
  assign leap = ((mod4 == 2'd0) && (mod100 != 7'd0)) || (mod400 == 9'd0);
  assign ylen = leap ? LEAP_DAYS : YEAR_DAYS;
  assign mlen = month_len(mon, leap);

  assign stat.y_ge     = (days >= DAYS_W'(ylen));
  assign stat.m_ge     = (mon != LAST_MONTH) && (days >= DAYS_W'(mlen));
  assign stat.out_busy = out_valid && !out_ready;

  // the program only reaches this step once the output register is free
  assign emit_fire = (ctl.op == OP_EMIT);

  always_ff @(posedge clk) begin
    case (ctl.op)
      OP_IDLE: begin
        if (in_valid) begin
          rem    <= epoch_seconds;
          yr     <= BASE_YEAR;
          mod4   <= BASE_MOD4;
          mod100 <= BASE_MOD100;
          mod400 <= BASE_MOD400;
          mon    <= 4'd1;
        end
      end
      OP_DIV: begin
        case (ctl.dsel)
          DS_DAY:  days <= quo;
          DS_HOUR: hr   <= quo[4:0];
          DS_MIN:  mn   <= quo[5:0];
          default: days <= quo;
        endcase
      end
      OP_REM: begin
        rem <= rem - back;
      end
      OP_YEAR: begin
        if (stat.y_ge) begin
          days   <= days - DAYS_W'(ylen);
          yr     <= yr + YEAR_W'(1);
          mod4   <= mod4 + 2'd1;
          mod100 <= (mod100 == LAST_MOD100) ? 7'd0 : mod100 + 7'd1;
          mod400 <= (mod400 == LAST_MOD400) ? 9'd0 : mod400 + 9'd1;
        end
      end
      OP_MONTH: begin
        if (stat.m_ge) begin
          days <= days - DAYS_W'(mlen);
          mon  <= mon + 4'd1;
        end
      end
      default: begin
      end
    endcase

    if (emit_fire) begin
      year   <= yr;
      month  <= mon;
      day    <= days[4:0] + 5'd1;
      hour   <= hr;
      minute <= mn;
      second <= rem[5:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// ===== rtl/unix_seconds_to_calendar_date_core.sv =====
// ----------------------------------------------------------------------------
// unix_seconds_to_calendar_date_core
// Converts unsigned seconds since 1970-01-01 00:00:00 to calendar date and time.
// ----------------------------------------------------------------------------
// an accepted transaction runs the day divide and remainder, steps off Y years
// past 1970 (0..136) and M months (0..11), then runs the hour and minute divides
// and remainders and the emit step; a result still waiting in the output
// register holds the minute divide; a new transaction is taken only in the idle
// step, and the microprogram steps off one year or one month per cycle
// reset clears the step counter and out_valid; no other state
module unix_seconds_to_calendar_date_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] epoch_seconds,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [11:0] year,
  output logic [3:0]  month,
  output logic [4:0]  day,
  output logic [4:0]  hour,
  output logic [5:0]  minute,
  output logic [5:0]  second
);
  import u2cal_pkg::*;

  uword_t  ctl;
  status_t stat;

  u2cal_useq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .stat     (stat),
    .ctl      (ctl),
    .in_ready (in_ready)
  );

  u2cal_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .in_valid      (in_valid),
    .epoch_seconds (epoch_seconds),
    .out_ready     (out_ready),
    .stat          (stat),
    .out_valid     (out_valid),
    .year          (year),
    .month         (month),
    .day           (day),
    .hour          (hour),
    .minute        (minute),
    .second        (second)
  );

endmodule
